// ----- hw/rtl/wsm_pkg.sv -----
// ----------------------------------------------------------------------------
// wsm_pkg
// shared constants and register codes of the wildcard string matcher
// ----------------------------------------------------------------------------
package wsm_pkg;

    localparam int BYTE_W                = 8;
    localparam int LEN_W                 = 6;
    localparam int CFG_DATA_W            = 64;
    localparam int CFG_INDEX_W           = 3;
    localparam int REG_BYTES             = 32;
    localparam int BYTES_PER_REG         = CFG_DATA_W / BYTE_W;
    localparam int MAX_PATTERN_BYTES_DEF = 32;

    localparam logic [BYTE_W-1:0] STAR_BYTE  = 8'h2A;
    localparam logic [BYTE_W-1:0] QUERY_BYTE = 8'h3F;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_A = 3'd0,
        REG_PATTERN_B = 3'd1,
        REG_PATTERN_C = 3'd2,
        REG_PATTERN_D = 3'd3,
        REG_LENGTH    = 3'd4
    } cfg_reg_t;

endpackage

// ----- hw/rtl/wsm_closure.sv -----
// ----------------------------------------------------------------------------
// wsm_closure
// parallel prefix network that spreads active positions across star bytes
// ----------------------------------------------------------------------------
module wsm_closure
    import wsm_pkg::*;
#(
    parameter int N = MAX_PATTERN_BYTES_DEF + 1
)
(
    input  logic [N-1:0] gen,
    input  logic [N-2:0] prop,
    output logic [N-1:0] closed
);

    localparam int LEVELS = $clog2(N);

    logic [N-1:0] g_cur;
    logic [N-1:0] p_cur;
    logic [N-1:0] g_new;
    logic [N-1:0] p_new;

    // p_cur[j]: position j-1 hands its activity on to j
    always_comb
    begin
        g_cur = gen;
        p_cur = {prop, 1'b0};
        g_new = gen;
        p_new = {prop, 1'b0};
        for (int l = 0; l < LEVELS; l++)
        begin
            for (int j = 0; j < N; j++)
            begin
                if (j >= (1 << l))
                begin
                    g_new[j] = g_cur[j] | (p_cur[j] & g_cur[j - (1 << l)]);
                    p_new[j] = p_cur[j] & p_cur[j - (1 << l)];
                end
                else
                begin
                    g_new[j] = g_cur[j];
                    p_new[j] = 1'b0;
                end
            end
            g_cur = g_new;
            p_cur = p_new;
        end
        closed = g_cur;
    end

endmodule

// ----- hw/rtl/wsm_cfg.sv -----
// ----------------------------------------------------------------------------
// wsm_cfg
// pattern and length registers with per-position decode
// ----------------------------------------------------------------------------
module wsm_cfg
    import wsm_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [CFG_INDEX_W-1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0]             cfg_data,
    output logic                              cfg_restart,
    output logic [MAX_PATTERN_BYTES*BYTE_W-1:0] pattern,
    output logic [MAX_PATTERN_BYTES-1:0]      star_pos,
    output logic [MAX_PATTERN_BYTES-1:0]      query_pos,
    output logic [MAX_PATTERN_BYTES-1:0]      in_use,
    output logic [MAX_PATTERN_BYTES:0]        end_pos
);

    localparam int P = MAX_PATTERN_BYTES;

    logic [LEN_W-1:0] length_reg;
    logic             known_index;
    logic             write_length;

    always_comb
    begin
        known_index  = 1'b0;
        write_length = 1'b0;
        unique case (cfg_reg_t'(cfg_index))
            REG_PATTERN_A, REG_PATTERN_B, REG_PATTERN_C, REG_PATTERN_D:
            begin
                known_index = 1'b1;
            end
            REG_LENGTH:
            begin
                known_index  = 1'b1;
                write_length = 1'b1;
            end
            default:
            begin
                known_index = 1'b0;
            end
        endcase
    end

    assign cfg_restart = cfg_write & known_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else if (cfg_write && write_length)
        begin
            length_reg <= cfg_data[LEN_W-1:0];
        end
    end

    for (genvar pos = 0; pos < P; pos++)
    begin : g_pos
        if (pos < REG_BYTES)
        begin : g_stored
            localparam logic [CFG_INDEX_W-1:0] OWN_REG = CFG_INDEX_W'(pos / BYTES_PER_REG);
            localparam int BYTE_SEL = pos % BYTES_PER_REG;
            logic [BYTE_W-1:0] byte_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    byte_reg <= '0;
                end
                else if (cfg_write && (cfg_index == OWN_REG))
                begin
                    byte_reg <= cfg_data[BYTE_SEL*BYTE_W +: BYTE_W];
                end
            end

            assign pattern[pos*BYTE_W +: BYTE_W] = byte_reg;
        end
        else
        begin : g_unstored
            // no register bytes back these positions
            assign pattern[pos*BYTE_W +: BYTE_W] = '0;
        end

        // lengths above the capacity clamp, so pos < length is enough
        assign in_use[pos]    = ((LEN_W+1)'(pos) < {1'b0, length_reg});
        assign star_pos[pos]  = in_use[pos] & (pattern[pos*BYTE_W +: BYTE_W] == STAR_BYTE);
        assign query_pos[pos] = in_use[pos] & (pattern[pos*BYTE_W +: BYTE_W] == QUERY_BYTE);
    end

    // end position one-hot, empty for a zero length
    assign end_pos[0] = 1'b0;
    for (genvar j = 1; j <= P; j++)
    begin : g_end
        if (j < P)
        begin : g_exact
            assign end_pos[j] = ({1'b0, length_reg} == (LEN_W+1)'(j));
        end
        else
        begin : g_clamp
            assign end_pos[j] = ({1'b0, length_reg} >= (LEN_W+1)'(j));
        end
    end

endmodule

// ----- hw/rtl/wsm_step.sv -----
// ----------------------------------------------------------------------------
// wsm_step
// advances the active position vector by one subject byte
// ----------------------------------------------------------------------------
module wsm_step
    import wsm_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
)
(
    input  logic [MAX_PATTERN_BYTES:0]          active,
    input  logic [BYTE_W-1:0]                   subject_byte,
    input  logic [MAX_PATTERN_BYTES*BYTE_W-1:0] pattern,
    input  logic [MAX_PATTERN_BYTES-1:0]        star_pos,
    input  logic [MAX_PATTERN_BYTES-1:0]        query_pos,
    input  logic [MAX_PATTERN_BYTES-1:0]        in_use,
    output logic [MAX_PATTERN_BYTES:0]          next_active
);

    localparam int P = MAX_PATTERN_BYTES;

    logic [P-1:0] stay;
    logic [P-1:0] advance;
    logic [P:0]   gen;

    for (genvar i = 0; i < P; i++)
    begin : g_pos
        // a star keeps its position, any other byte consumes one pattern byte
        assign stay[i]    = active[i] & star_pos[i];
        assign advance[i] = active[i] & in_use[i] & ~star_pos[i]
                          & (query_pos[i] | (pattern[i*BYTE_W +: BYTE_W] == subject_byte));
    end

    assign gen = {advance, 1'b0} | {1'b0, stay};

    wsm_closure #(
        .N (P + 1)
    ) u_closure (
        .gen    (gen),
        .prop   (star_pos),
        .closed (next_active)
    );

endmodule

// ----- hw/rtl/wildcard_string_matcher_top.sv -----
// ----------------------------------------------------------------------------
// wildcard_string_matcher_top
// streaming glob matcher of subject bytes against a configured pattern
// ----------------------------------------------------------------------------
// usage
//   input channel  in_valid / in_stall carries subject_byte and end_of_subject
//   output channel out_valid / out_stall carries matched and final_result,
//   one result transfer for every input transfer, in order
//   config port    cfg_write / cfg_index / cfg_data writes pattern bytes and
//   the length; any known write restarts the current subject
// throughput
//   one byte per cycle sustained while results are not stalled; a result passes
//   through the input register, then the result register; the combinational path is
//   the per-position byte compare followed by the star prefix network
// reset
//   pattern and length clear to zero, so nothing matches until configured;
//   the next byte starts a new subject
// stalls
//   a stalled result holds; the input register keeps taking one more byte,
//   then in_stall rises until the result transfer goes through
// ----------------------------------------------------------------------------
module wildcard_string_matcher_top
    import wsm_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // input channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [BYTE_W-1:0]      subject_byte,
    input  logic                   end_of_subject,
    // output channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   matched,
    output logic                   final_result,
    // configuration
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int P = MAX_PATTERN_BYTES;

    // configuration view
    logic                   cfg_restart;
    logic [P*BYTE_W-1:0]    pattern;
    logic [P-1:0]           star_pos;
    logic [P-1:0]           query_pos;
    logic [P-1:0]           in_use;
    logic [P:0]             end_pos;

    // input register
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic [BYTE_W-1:0]      s1_byte_reg;
    logic                   s1_last_reg;

    // matcher state
    logic [P:0]             active_reg;
    logic [P:0]             active_next;
    logic                   restart_reg;
    logic                   restart_next;
    logic [P:0]             restart_vec;
    logic [P:0]             cur_active;
    logic [P:0]             step_active;

    // result register
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   matched_reg;
    logic                   final_reg;

    logic                   out_free;
    logic                   fire;
    logic                   in_transfer;

    wsm_cfg #(
        .MAX_PATTERN_BYTES (P)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cfg_restart (cfg_restart),
        .pattern     (pattern),
        .star_pos    (star_pos),
        .query_pos   (query_pos),
        .in_use      (in_use),
        .end_pos     (end_pos)
    );

    // start state: position 0 plus the run of leading stars
    wsm_closure #(
        .N (P + 1)
    ) u_restart (
        .gen    ((P+1)'(1)),
        .prop   (star_pos),
        .closed (restart_vec)
    );

    // a pending restart stands in for the stored vector
    assign cur_active = restart_reg ? restart_vec : active_reg;

    wsm_step #(
        .MAX_PATTERN_BYTES (P)
    ) u_step (
        .active       (cur_active),
        .subject_byte (s1_byte_reg),
        .pattern      (pattern),
        .star_pos     (star_pos),
        .query_pos    (query_pos),
        .in_use       (in_use),
        .next_active  (step_active)
    );

    // handshake: the result register frees when empty or when it transfers
    assign out_free    = !out_valid_reg || !out_stall;
    assign fire        = s1_valid_reg && out_free;
    assign in_stall    = s1_valid_reg && !out_free;
    assign in_transfer = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next  = in_transfer || (s1_valid_reg && !fire);
        out_valid_next = fire || (out_valid_reg && out_stall);
        active_next    = fire ? step_active : active_reg;
        restart_next   = restart_reg;
        if (fire)
        begin
            // the last byte of a subject arms a restart for the next one
            restart_next = s1_last_reg;
        end
        if (cfg_restart)
        begin
            restart_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            restart_reg   <= 1'b1;
            active_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            restart_reg   <= restart_next;
            active_reg    <= active_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            s1_byte_reg <= subject_byte;
            s1_last_reg <= end_of_subject;
        end
        if (fire)
        begin
            matched_reg <= |(step_active & end_pos);
            final_reg   <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign matched      = matched_reg;
    assign final_result = final_reg;

endmodule

// ----- hw/rtl/wsm_checker.sv -----
// ----------------------------------------------------------------------------
// wsm_checker
// port-level checks of the wildcard string matcher, bound to the top level
// ----------------------------------------------------------------------------
module wsm_checker
    import wsm_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic                   matched,
    input logic                   final_result,
    input logic                   cfg_write,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;
    logic       len_zero_reg;
    logic       len_zero_next;

    always_comb
    begin
        inflight_next = inflight_reg
                      + 2'(in_valid && !in_stall)
                      - 2'(out_valid && !out_stall);
        len_zero_next = len_zero_reg;
        if (cfg_write && (cfg_index == REG_LENGTH))
        begin
            len_zero_next = (cfg_data[LEN_W-1:0] == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
            len_zero_reg <= 1'b1;
        end
        else
        begin
            inflight_reg <= inflight_next;
            len_zero_reg <= len_zero_next;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(matched) && $stable(final_result))
        else $error("result changed while stalled");

    // at most two items between input and output
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg != 2'd3)
        else $error("more items in flight than storage");

    // no result without a pending item
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 2'd0)
        else $error("result without an accepted item");

    // input backpressure only when the result side is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall && inflight_reg == 2'd2)
        else $error("input stalled without a blocked result");

    // a zero-length pattern never matches
    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && len_zero_reg |-> !matched)
        else $error("match reported for an empty pattern");

endmodule

bind wildcard_string_matcher_top wsm_checker u_wsm_checker (.*);

// ----- sim/tb_wildcard_string_matcher_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wildcard_string_matcher_top
// self-checking bench for the streaming glob matcher: a clocked driver sends
// subject bytes from a queue, a bit-vector model of the pattern positions
// predicts every result, and a clocked monitor compares each result transfer
// with the oldest prediction while both sides idle and stall at random
// ----------------------------------------------------------------------------
module tb_wildcard_string_matcher_top;

    import wsm_pkg::*;

    localparam int NPOS        = MAX_PATTERN_BYTES_DEF;
    localparam int NUM_PAT_REG = REG_BYTES / BYTES_PER_REG;
    localparam int TOTAL_ITEMS = 1150;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 100;

    // index just past the last defined register; everything from here is unused
    localparam logic [CFG_INDEX_W-1:0] FIRST_STRAY_REG = CFG_INDEX_W'(REG_LENGTH + 1);
    localparam logic [CFG_INDEX_W-1:0] LAST_STRAY_REG  = '1;

    localparam logic [BYTE_W-1:0] LETTER_A = "a";

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
    } subject_xfer_t;

    typedef struct {
        logic [BYTE_W-1:0] subj;
        logic              hit;
        logic              last;
    } match_verdict_t;

    // clock, reset and block ports; every signal the bench drives is known from time zero
    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   in_valid       = 1'b0;
    logic                   in_stall;
    logic [BYTE_W-1:0]      subject_byte   = '0;
    logic                   end_of_subject = 1'b0;
    logic                   out_valid;
    logic                   out_stall      = 1'b0;
    logic                   matched;
    logic                   final_result;
    logic                   cfg_write      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  cfg_data       = '0;

    // pattern model: configured bytes, length and the live position vector
    logic [BYTE_W-1:0] pat_byte [NPOS];
    logic [LEN_W-1:0]  pat_len = '0;
    logic [NPOS:0]     live_pos;

    // pattern staged by the stimulus before it goes out over the config port
    logic [BYTE_W-1:0] plan_pat [REG_BYTES];

    subject_xfer_t  subject_q [$];
    match_verdict_t verdict_q [$];

    int          items_queued = 0;
    int          fail_count   = 0;
    int          quiet_cycles = 0;
    int unsigned send_gap     = 0;
    int unsigned recv_hold    = 0;
    bit          no_idle      = 1'b0;

    wildcard_string_matcher_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .subject_byte   (subject_byte),
        .end_of_subject (end_of_subject),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .matched        (matched),
        .final_result   (final_result),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    // 20 ns period
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // pattern position model
    // ------------------------------------------------------------------------

    // lengths above the position count are clamped
    function automatic int unsigned used_len();
        return (pat_len > NPOS) ? NPOS : int'(pat_len);
    endfunction

    // a star may match an empty run, so a live star also lights the next slot;
    // ascending order carries this through runs of stars
    function automatic void spread_stars();
        int unsigned n;
        n = used_len();
        for (int unsigned i = 0; i < n; i++)
            if (live_pos[i] && pat_byte[i] == STAR_BYTE)
                live_pos[i+1] = 1'b1;
    endfunction

    function automatic void restart_subject();
        live_pos    = '0;
        live_pos[0] = 1'b1;
        spread_stars();
    endfunction

    // register write as the block sees it; unused indexes change nothing
    function automatic void apply_reg_write(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0]  val);
        case (idx)
            REG_PATTERN_A, REG_PATTERN_B, REG_PATTERN_C, REG_PATTERN_D:
                for (int b = 0; b < BYTES_PER_REG; b++)
                    pat_byte[int'(idx) * BYTES_PER_REG + b] = val[BYTE_W*b +: BYTE_W];
            REG_LENGTH:
                pat_len = val[LEN_W-1:0];
            default:
                return;
        endcase
        restart_subject();
    endfunction

    // consume one subject byte, return whether the whole pattern is matched
    function automatic logic advance_match(input logic [BYTE_W-1:0] c,
                                           input logic              last);
        logic [NPOS:0] nxt;
        int unsigned   n;
        logic          hit;
        n   = used_len();
        nxt = '0;
        for (int unsigned i = 0; i < n; i++)
        begin
            if (live_pos[i])
            begin
                if (pat_byte[i] == STAR_BYTE)
                    nxt[i] = 1'b1;
                else if (pat_byte[i] == QUERY_BYTE || pat_byte[i] == c)
                    nxt[i+1] = 1'b1;
            end
        end
        live_pos = nxt;
        spread_stars();
        hit = (n != 0) && live_pos[n];
        if (last)
            restart_subject();
        return hit;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [BYTE_W-1:0] pick_subject_byte();
        if ($urandom_range(0, 4) == 0)
            return BYTE_W'($urandom_range(0, 255));
        return LETTER_A + BYTE_W'($urandom_range(0, 2));
    endfunction

    function automatic logic [BYTE_W-1:0] pick_pattern_byte();
        case ($urandom_range(0, 11))
            0, 1, 2: return STAR_BYTE;
            3, 4:    return QUERY_BYTE;
            5:       return '0;
            6:       return BYTE_W'($urandom_range(0, 255));
            default: return LETTER_A + BYTE_W'($urandom_range(0, 2));
        endcase
    endfunction

    function automatic void queue_byte(input logic [BYTE_W-1:0] value, input logic last);
        subject_q.push_back('{value: value, last: last});
        items_queued++;
    endfunction

    // one subject: mostly built to fit the current pattern (sometimes damaged),
    // otherwise noise; an open subject gets no end flag on its final byte
    task automatic queue_subject(input bit leave_open);
        logic [BYTE_W-1:0] s [$];
        int unsigned       n;
        int unsigned       k;
        n = used_len();
        if ($urandom_range(0, 9) < 7)
        begin
            for (int unsigned i = 0; i < n; i++)
            begin
                if (pat_byte[i] == STAR_BYTE)
                    repeat ($urandom_range(0, 3)) s.push_back(pick_subject_byte());
                else if (pat_byte[i] == QUERY_BYTE)
                    s.push_back(BYTE_W'($urandom_range(0, 255)));
                else
                    s.push_back(pat_byte[i]);
            end
            case ($urandom_range(0, 7))
                0:
                begin
                    if (s.size() != 0)
                    begin
                        k    = $urandom_range(0, s.size() - 1);
                        s[k] = s[k] ^ BYTE_W'($urandom_range(1, 255));
                    end
                end
                1: if (s.size() != 0) void'(s.pop_back());
                2: s.push_back(pick_subject_byte());
                default: ;
            endcase
        end
        else
        begin
            repeat ($urandom_range(1, 8)) s.push_back(pick_subject_byte());
        end
        if (s.size() == 0)
            s.push_back(pick_subject_byte());
        foreach (s[j])
            queue_byte(s[j], !leave_open && j == s.size() - 1);
    endtask

    // every queued byte sent and every result back, then a short margin
    task automatic wait_drained();
        do
            @(negedge clk);
        while (subject_q.size() != 0 || in_valid || verdict_q.size() != 0);
        repeat (2) @(negedge clk);
    endtask

    // write enable stays high across back-to-back writes
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0]  val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        apply_reg_write(idx, val);
    endtask

    task automatic settle_writes();
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // push the staged pattern into all four byte registers, then the length
    task automatic program_plan(input logic [CFG_DATA_W-1:0] len_word);
        logic [CFG_DATA_W-1:0] word;
        for (int r = 0; r < NUM_PAT_REG; r++)
        begin
            for (int b = 0; b < BYTES_PER_REG; b++)
                word[BYTE_W*b +: BYTE_W] = plan_pat[r * BYTES_PER_REG + b];
            write_reg(REG_PATTERN_A + CFG_INDEX_W'(r), word);
        end
        write_reg(REG_LENGTH, len_word);
        settle_writes();
    endtask

    task automatic report_mismatch(input string msg);
        fail_count++;
        // keep the log bounded if the block goes badly wrong
        if (fail_count <= MAX_REPORTS)
            $display("[%0t ns] mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // driver: one subject transfer at a time, random gap before each
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : subject_driver
        subject_xfer_t nxt_item;
        logic          hit;
        if (!rst_n)
        begin
            in_valid       <= 1'b0;
            subject_byte   <= '0;
            end_of_subject <= 1'b0;
            send_gap       <= 0;
        end
        else
        begin
            // transfer taken at this edge: predict its result now
            if (in_valid && !in_stall)
            begin
                hit = advance_match(subject_byte, end_of_subject);
                verdict_q.push_back('{subj: subject_byte, hit: hit, last: end_of_subject});
            end
            // a stalled payload holds; otherwise pick what goes out next
            if (!in_valid || !in_stall)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (subject_q.size() != 0)
                begin
                    nxt_item       = subject_q.pop_front();
                    in_valid       <= 1'b1;
                    subject_byte   <= nxt_item.value;
                    end_of_subject <= nxt_item.last;
                    send_gap       <= no_idle ? 0 : $urandom_range(0, 3);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random stall before each result, then a field-by-field compare
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        match_verdict_t want;
        int unsigned    hold_draw;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_hold <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
            begin
                report_mismatch("result transfer with no subject byte outstanding");
            end
            else
            begin
                want = verdict_q.pop_front();
                if (matched !== want.hit)
                    report_mismatch($sformatf("matched %b, expected %b (byte 8'h%h)",
                                              matched, want.hit, want.subj));
                if (final_result !== want.last)
                    report_mismatch($sformatf("final_result %b, expected %b (byte 8'h%h)",
                                              final_result, want.last, want.subj));
            end
            hold_draw = no_idle ? 0 : $urandom_range(0, 3);
            recv_hold <= hold_draw;
            out_stall <= (hold_draw != 0);
        end
        else if (recv_hold != 0)
        begin
            recv_hold <= recv_hold - 1;
            out_stall <= (recv_hold != 1);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any transfer on either channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("wildcard_string_matcher_top verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus: directed corner cases, then random phases under new patterns
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] len_word;
        logic [LEN_W-1:0]      len_pick;
        bit                    all_ones;
        int                    phase_end;

        // model starts where the block does after reset
        for (int i = 0; i < NPOS; i++)
            pat_byte[i] = '0;
        pat_len = '0;
        restart_subject();
        foreach (plan_pat[i])
            plan_pat[i] = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero length after reset: never a match, end flag still passes through
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(STAR_BYTE, 1'b1);
        wait_drained();

        // pattern a * ? <zero byte>; a zero byte in the subject must match it
        plan_pat[0] = LETTER_A;
        plan_pat[1] = STAR_BYTE;
        plan_pat[2] = QUERY_BYTE;
        plan_pat[3] = 8'h00;
        program_plan(CFG_DATA_W'(4));
        queue_byte(LETTER_A, 1'b0);
        queue_byte("x", 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte("y", 1'b1);
        // leave a subject open, then write an unused index: no restart
        queue_byte(LETTER_A, 1'b0);
        wait_drained();
        write_reg(FIRST_STRAY_REG, '1);
        settle_writes();
        queue_byte("z", 1'b0);
        queue_byte(8'h00, 1'b1);
        // open subject again; rewriting the length must restart it
        queue_byte(LETTER_A, 1'b0);
        wait_drained();
        write_reg(REG_LENGTH, CFG_DATA_W'(4));
        settle_writes();
        queue_byte("q", 1'b0);
        queue_byte(8'h00, 1'b1);
        wait_drained();

        // every register all ones: length 63 is clamped to the position count
        foreach (plan_pat[i])
            plan_pat[i] = '1;
        program_plan('1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b1);
        wait_drained();

        // full-length run of stars matches from the very first byte
        foreach (plan_pat[i])
            plan_pat[i] = STAR_BYTE;
        program_plan(CFG_DATA_W'(NPOS));
        queue_byte(8'h55, 1'b1);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h00, 1'b1);
        wait_drained();

        // random phases; each ends with the block drained, which also gives
        // the pause with nothing outstanding before the next pattern
        while (items_queued < TOTAL_ITEMS)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) != 0)
            begin
                all_ones = ($urandom_range(0, 7) == 0);
                foreach (plan_pat[i])
                    plan_pat[i] = all_ones ? 8'hFF : pick_pattern_byte();
                case ($urandom_range(0, 9))
                    0:       len_pick = '0;
                    1:       len_pick = LEN_W'($urandom_range(NPOS + 1, 63));
                    2:       len_pick = LEN_W'(NPOS);
                    3, 4:    len_pick = LEN_W'($urandom_range(9, NPOS - 1));
                    default: len_pick = LEN_W'($urandom_range(1, 8));
                endcase
                // bits above the length field are don't-care to the block
                len_word            = {$urandom, $urandom};
                len_word[LEN_W-1:0] = len_pick;
                program_plan(len_word);
            end
            phase_end = items_queued + $urandom_range(40, 70);
            while (items_queued < phase_end)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    // unused index in the middle of a subject
                    queue_subject(1'b1);
                    wait_drained();
                    write_reg(CFG_INDEX_W'($urandom_range(FIRST_STRAY_REG, LAST_STRAY_REG)),
                              {$urandom, $urandom});
                    settle_writes();
                end
                else
                begin
                    queue_subject(1'b0);
                end
            end
            // sometimes leave the subject open across the next pattern write
            if ($urandom_range(0, 2) == 0)
                queue_subject(1'b1);
            wait_drained();
        end

        wait_drained();
        repeat (4) @(negedge clk);
        if (fail_count == 0)
            $display("wildcard_string_matcher_top verification clean");
        else
            $display("wildcard_string_matcher_top verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/wsm_pkg.sv
hw/rtl/wsm_closure.sv
hw/rtl/wsm_cfg.sv
hw/rtl/wsm_step.sv
hw/rtl/wildcard_string_matcher_top.sv
hw/rtl/wsm_checker.sv
sim/tb_wildcard_string_matcher_top.sv
